// ----- src/aplp_pkg.sv -----
// aplp_pkg: types and codes shared by the authentication parameter list parser.
// Holds the input/result payload structs, the classified queue entry and role/status codes.
// No dependencies.
`timescale 1ns / 1ps

package aplp_pkg;

  localparam int BYTE_W = 8;

  localparam logic [1:0] ROLE_NONE  = 2'd0;
  localparam logic [1:0] ROLE_NAME  = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;

  localparam logic [1:0] STATUS_BUSY = 2'd0;
  localparam logic [1:0] STATUS_OK   = 2'd1;
  localparam logic [1:0] STATUS_ERR  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [1:0]        char_role;
    logic              pair_done;
    logic [1:0]        status;
  } out_item_t;

  // Request as it travels from the classifier to the parser state machine
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              last;
    logic              is_alnum;
    logic              is_space;
    logic              is_equals;
    logic              is_quote;
    logic              is_bslash;
    logic              is_comma;
  } cls_item_t;

endpackage

// ----- src/aplp_front.sv -----
// aplp_front: accepts input requests and classifies the character.
// Depends on aplp_pkg.
`timescale 1ns / 1ps

module aplp_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  aplp_pkg::in_item_t  in_data,
  output logic              push,
  output aplp_pkg::cls_item_t push_data,
  input  logic              q_full
);
  import aplp_pkg::*;

  logic [BYTE_W-1:0] c;

  assign c        = in_data.data_byte;
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data.data_byte = c;
    push_data.has_byte  = in_data.has_byte;
    push_data.last      = in_data.last;
    push_data.is_alnum  = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                          (c >= 8'h61 && c <= 8'h7A);
    push_data.is_space  = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
    push_data.is_equals = (c == CH_EQUALS);
    push_data.is_quote  = (c == CH_QUOTE);
    push_data.is_bslash = (c == CH_BSLASH);
    push_data.is_comma  = (c == CH_COMMA);
  end

endmodule

// ----- src/aplp_queue.sv -----
// aplp_queue: two-entry queue of classified requests between front and back.
// Depends on aplp_pkg.
`timescale 1ns / 1ps

module aplp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  aplp_pkg::cls_item_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output aplp_pkg::cls_item_t q_data
);
  import aplp_pkg::*;

  cls_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/aplp_back.sv -----
// aplp_back: parser state machine and result register.
// Steps once per classified request taken from aplp_queue. Depends on aplp_pkg.
`timescale 1ns / 1ps

module aplp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  aplp_pkg::cls_item_t q_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output aplp_pkg::out_item_t out_data
);
  import aplp_pkg::*;

  localparam logic [2:0] ST_SPACE  = 3'd0;
  localparam logic [2:0] ST_TOKEN  = 3'd1;
  localparam logic [2:0] ST_EQUALS = 3'd2;
  localparam logic [2:0] ST_VALUE  = 3'd3;
  localparam logic [2:0] ST_QUOTED = 3'd4;
  localparam logic [2:0] ST_ESCAPE = 3'd5;
  localparam logic [2:0] ST_COMMA  = 3'd6;
  localparam logic [2:0] ST_ERROR  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] step_st;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r;
  out_item_t  res;
  logic [1:0] role;
  logic       done;

  // Take a request whenever the result register is free or being drained
  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    role    = ROLE_NONE;
    done    = 1'b0;
    step_st = state_r;
    if (q_data.has_byte) begin
      unique case (state_r)
        ST_SPACE: begin
          if (q_data.is_alnum) begin
            role    = ROLE_NAME;
            step_st = ST_TOKEN;
          end else if (!q_data.is_space) begin
            step_st = ST_ERROR;
          end
        end
        ST_TOKEN: begin
          if (q_data.is_equals) begin
            step_st = ST_EQUALS;
          end else if (q_data.is_alnum) begin
            role = ROLE_NAME;
          end else begin
            step_st = ST_ERROR;
          end
        end
        ST_EQUALS: begin
          if (q_data.is_alnum) begin
            role    = ROLE_VALUE;
            step_st = ST_VALUE;
          end else if (q_data.is_quote) begin
            step_st = ST_QUOTED;
          end else begin
            step_st = ST_ERROR;
          end
        end
        ST_QUOTED: begin
          if (q_data.is_bslash) begin
            step_st = ST_ESCAPE;
          end else if (q_data.is_quote) begin
            done    = 1'b1;
            step_st = ST_COMMA;
          end else begin
            role = ROLE_VALUE;
          end
        end
        ST_ESCAPE: begin
          role    = ROLE_VALUE;
          step_st = ST_QUOTED;
        end
        ST_VALUE: begin
          if (q_data.is_space) begin
            done    = 1'b1;
            step_st = ST_COMMA;
          end else if (q_data.is_comma) begin
            done    = 1'b1;
            step_st = ST_SPACE;
          end else begin
            role = ROLE_VALUE;
          end
        end
        ST_COMMA: begin
          if (q_data.is_comma) begin
            step_st = ST_SPACE;
          end else if (!q_data.is_space) begin
            step_st = ST_ERROR;
          end
        end
        default: begin
          step_st = ST_ERROR;
        end
      endcase
    end

    res.status    = STATUS_BUSY;
    state_nxt     = step_st;
    if (q_data.last) begin
      // Close an open unquoted value at end of string
      if (step_st == ST_VALUE) begin
        done       = 1'b1;
        res.status = STATUS_OK;
      end else if (step_st == ST_COMMA) begin
        res.status = STATUS_OK;
      end else begin
        res.status = STATUS_ERR;
      end
      state_nxt = ST_SPACE;
    end
    res.char_role = role;
    res.pair_done = done;
    res.out_byte  = (role != ROLE_NONE) ? q_data.data_byte : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SPACE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

endmodule

// ----- src/auth_param_list_parser_top.sv -----
// Byte-serial parser for an authentication parameter list (name=value, name="quoted").
//
// Input channel in_valid/in_ready/in_data: one character per request, with has_byte
// marking a real byte and last marking the end of the string. Result channel
// out_valid/out_ready/out_data: exactly one result per input request, in order,
// giving the character role (name or value), pair completion and, on the last
// request, accepted or syntax error.
// A classifier front end writes each request into a two-entry queue; the state machine
// back end takes one request per cycle from it into a result register unless stalled.
// An accepted request passes the queue entry, then the result register, to out_valid.
// Throughput: one request per cycle while not stalled, set by the parser state step.
// Reset (rst_n low, synchronous): queue emptied, result register invalid, parser
// back in its initial whitespace-skipping state.
// When the receiver stalls, the result holds in its register, the queue fills, and
// in_ready drops once both queue entries are taken.
// Depends on aplp_pkg, aplp_front, aplp_queue, aplp_back.
`timescale 1ns / 1ps

module auth_param_list_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aplp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aplp_pkg::out_item_t out_data
);
  import aplp_pkg::*;

  logic      push;
  cls_item_t push_data;
  logic      q_full;
  logic      pop;
  logic      q_valid;
  cls_item_t q_data;

  aplp_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  aplp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  aplp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- src/aplp_checker.sv -----
// aplp_port_checks: port-level assertions for auth_param_list_parser_top, bound to the top.
// Depends on aplp_pkg.
`timescale 1ns / 1ps

module aplp_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input aplp_pkg::out_item_t out_data
);
  import aplp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.char_role == ROLE_NONE |-> out_data.out_byte == '0)
    else $error("byte echoed without a role");

  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.char_role != 2'd3 && out_data.status != 2'd3)
    else $error("undefined role or status code");

  a_ok_not_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_OK |-> out_data.char_role != ROLE_NAME)
    else $error("string accepted while inside a name");

endmodule

bind auth_param_list_parser_top aplp_port_checks u_aplp_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- test/aplp_checker.sv -----
// aplp_checker: watches both channels of the parameter list parser, predicts each result
// from the accepted requests, and compares it field by field with what the block returns.
// Depends on aplp_pkg for the payload structs and the role/status codes.
`timescale 1ns / 1ps

module aplp_checker
  import aplp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        exp_pending
);

  typedef enum logic [2:0] {
    PS_SPACE, PS_TOKEN, PS_EQUALS, PS_VALUE, PS_QUOTED, PS_ESCAPE, PS_COMMA, PS_ERROR
  } parse_state_e;

  parse_state_e parse_st;
  out_item_t    pending_results[$];
  out_item_t    want;

  initial begin
    fail_count  = 0;
    exp_pending = 0;
    parse_st    = PS_SPACE;
  end

  function automatic bit is_name_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Advance the parser by one request and return the result it should produce
  function automatic out_item_t predict_parse(input in_item_t req);
    out_item_t   res;
    logic [7:0]  c;
    c   = req.data_byte;
    res = '0;
    if (req.has_byte) begin
      case (parse_st)
        PS_SPACE: begin
          if (is_name_char(c)) begin
            res.char_role = ROLE_NAME;
            parse_st = PS_TOKEN;
          end else if (!is_blank(c)) begin
            parse_st = PS_ERROR;
          end
        end
        PS_TOKEN: begin
          if (c == CH_EQUALS) parse_st = PS_EQUALS;
          else if (is_name_char(c)) res.char_role = ROLE_NAME;
          else parse_st = PS_ERROR;
        end
        PS_EQUALS: begin
          if (is_name_char(c)) begin
            res.char_role = ROLE_VALUE;
            parse_st = PS_VALUE;
          end else if (c == CH_QUOTE) begin
            parse_st = PS_QUOTED;
          end else begin
            parse_st = PS_ERROR;
          end
        end
        PS_QUOTED: begin
          if (c == CH_BSLASH) begin
            parse_st = PS_ESCAPE;
          end else if (c == CH_QUOTE) begin
            res.pair_done = 1'b1;
            parse_st = PS_COMMA;
          end else begin
            res.char_role = ROLE_VALUE;
          end
        end
        PS_ESCAPE: begin
          res.char_role = ROLE_VALUE;
          parse_st = PS_QUOTED;
        end
        PS_VALUE: begin
          if (is_blank(c)) begin
            res.pair_done = 1'b1;
            parse_st = PS_COMMA;
          end else if (c == CH_COMMA) begin
            res.pair_done = 1'b1;
            parse_st = PS_SPACE;
          end else begin
            res.char_role = ROLE_VALUE;
          end
        end
        PS_COMMA: begin
          if (c == CH_COMMA) parse_st = PS_SPACE;
          else if (!is_blank(c)) parse_st = PS_ERROR;
        end
        default: parse_st = PS_ERROR;
      endcase
    end
    if (req.last) begin
      // an unquoted value still open at the end completes its pair
      if (parse_st == PS_VALUE) begin
        res.pair_done = 1'b1;
        res.status = STATUS_OK;
      end else if (parse_st == PS_COMMA) begin
        res.status = STATUS_OK;
      end else begin
        res.status = STATUS_ERR;
      end
      parse_st = PS_SPACE;
    end
    if (res.char_role != ROLE_NONE) res.out_byte = c;
    return res;
  endfunction

  task automatic report(input string what, input logic [7:0] want_v, input logic [7:0] got_v);
    fail_count++;
    $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_st = PS_SPACE;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) pending_results.push_back(predict_parse(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result byte", 8'h00, out_data.out_byte);
        end else begin
          want = pending_results.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report("out_byte", want.out_byte, out_data.out_byte);
          if (out_data.char_role !== want.char_role)
            report("char_role", want.char_role, out_data.char_role);
          if (out_data.pair_done !== want.pair_done)
            report("pair_done", want.pair_done, out_data.pair_done);
          if (out_data.status !== want.status)
            report("status", want.status, out_data.status);
        end
      end
    end
    exp_pending = pending_results.size();
  end

endmodule

// ----- test/tb_top.sv -----
// tb_top: drives parameter strings into auth_param_list_parser_top with random gaps and
// stalls, and gives the verdict from the failure count of aplp_checker.
// Depends on aplp_pkg, aplp_checker and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
  import aplp_pkg::*;

  localparam int RAND_ITEMS  = 1200;
  localparam int DRAIN_LIMIT = 5000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        exp_pending;

  in_item_t  str_q[$];
  bit        quiet;
  int        req_cnt;

  auth_param_list_parser_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  aplp_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .exp_pending(exp_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // mostly back to back, sometimes a short gap, rarely a long hold
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_alnum();
    int k;
    k = $urandom_range(0, 61);
    if (k < 10) return 8'(32'h30 + k);
    if (k < 36) return 8'(32'h41 + (k - 10));
    return 8'(32'h61 + (k - 36));
  endfunction

  function automatic logic [7:0] pick_space();
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) return CH_SPACE;
    return 8'(32'h08 + k);
  endfunction

  // any byte that keeps an unquoted value open
  function automatic logic [7:0] pick_bare();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_COMMA || b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D));
    return b;
  endfunction

  function automatic logic [7:0] pick_quoted();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  task automatic add_req(input logic [7:0] b, input logic has);
    in_item_t req;
    req.data_byte = b;
    req.has_byte  = has;
    req.last      = 1'b0;
    str_q.push_back(req);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_req(s[i], 1'b1);
  endtask

  task automatic send_req(input in_item_t req);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_string();
    str_q[str_q.size() - 1].last = 1'b1;
    foreach (str_q[i]) begin
      send_req(str_q[i]);
      if (str_q[i].has_byte || str_q[i].last) req_cnt++;
    end
    str_q.delete();
  endtask

  // hold the sender until every result is back or DRAIN_LIMIT runs out
  task automatic wait_drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (exp_pending != 0 && waited < DRAIN_LIMIT);
    @(posedge clk);
  endtask

  task automatic build_random_string();
    int kind;
    int npairs;
    int k;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(0, 8))
        add_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      npairs = $urandom_range(1, 4);
      for (int p = 0; p < npairs; p++) begin
        repeat ($urandom_range(0, 2)) add_req(pick_space(), 1'b1);
        repeat ($urandom_range(1, 6)) add_req(pick_alnum(), 1'b1);
        add_req(CH_EQUALS, 1'b1);
        if ($urandom_range(0, 1)) begin
          add_req(CH_QUOTE, 1'b1);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) begin
              add_req(CH_BSLASH, 1'b1);
              add_req(8'($urandom_range(0, 255)), 1'b1);
            end else begin
              add_req(pick_quoted(), 1'b1);
            end
          end
          add_req(CH_QUOTE, 1'b1);
          repeat ($urandom_range(0, 2)) add_req(pick_space(), 1'b1);
          if (p < npairs - 1) add_req(CH_COMMA, 1'b1);
        end else begin
          add_req(pick_alnum(), 1'b1);
          repeat ($urandom_range(0, 5)) add_req(pick_bare(), 1'b1);
          if (p < npairs - 1) begin
            repeat ($urandom_range(0, 2)) add_req(pick_space(), 1'b1);
            add_req(CH_COMMA, 1'b1);
          end else begin
            repeat ($urandom_range(0, 2)) add_req(pick_space(), 1'b1);
          end
        end
      end
      if (kind < 20) begin
        // break one byte of an otherwise clean string
        k = $urandom_range(0, str_q.size() - 1);
        str_q[k].data_byte = 8'($urandom_range(0, 255));
      end else if (kind < 26) begin
        k = $urandom_range(0, str_q.size() - 1);
        while (str_q.size() > k) void'(str_q.pop_back());
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, str_q.size());
      add_req(8'($urandom_range(0, 255)), 1'b0);
      str_q.insert(k, str_q.pop_back());
    end
    // end the string on its own item now and then
    if (str_q.size() == 0 || $urandom_range(0, 3) == 0)
      add_req(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    int stall_len;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      stall_len = quiet ? 0 : gap_len();
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  initial begin
    bit drained_mid;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    req_cnt     = 0;
    drained_mid = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // open unquoted value closed by the end of the string
    add_text("a=1");
    send_string();
    // leading blank, blank and comma separators, escaped 0xFF, closing quote, end-only end
    add_text(" Z=9 ,b=\"\\");
    add_req(8'hFF, 1'b1);
    add_req(CH_QUOTE, 1'b1);
    add_req(8'h00, 1'b0);
    send_string();
    // ignored end-only request, then a zero byte as syntax error at the end
    add_req(8'hFF, 1'b0);
    str_q.push_back('{data_byte: 8'h00, has_byte: 1'b1, last: 1'b0});
    send_string();
    // empty string
    add_req(8'h00, 1'b0);
    send_string();
    // dangling comma
    add_text("x=y,");
    send_string();
    wait_drain();

    req_cnt = 0;
    while (req_cnt < RAND_ITEMS) begin
      if (!drained_mid && req_cnt >= RAND_ITEMS / 2) begin
        wait_drain();
        drained_mid = 1'b1;
      end
      quiet = ($urandom_range(0, 7) == 0);
      build_random_string();
      send_string();
    end
    quiet = 1'b0;

    wait_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && exp_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
